// ===== hdl/nearest_neighbor_fit_downscaler_unit_defines.svh =====
// Assertion macros for the fit downscaler unit.
// Clock i_clk and active-low reset i_rst_n are taken from the including scope.
`ifndef NEAREST_NEIGHBOR_FIT_DOWNSCALER_UNIT_DEFINES_SVH
`define NEAREST_NEIGHBOR_FIT_DOWNSCALER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define NNFD_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nnfd: same-cycle check failed");
// Check that cons holds in the cycle after ante.
`define NNFD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nnfd: next-cycle check failed");
`else
`define NNFD_ASSERT_SAME(name, ante, cons)
`define NNFD_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== hdl/nnfd_pkg.sv =====
// Shared types, constants and helpers of the fit downscaler.
// No dependencies.
package nnfd_pkg;

    localparam int DIM_BITS      = 12;
    localparam int PIX_BITS      = 32;
    localparam int ACC_BITS      = 2 * DIM_BITS;
    localparam int CFG_IDX_BITS  = 2;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    // Target size divider: one quotient bit per step
    localparam int DIV_STEPS     = ACC_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

    localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(450);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SRC_W = 2'd0,
        REG_SRC_H = 2'd1,
        REG_LIM_W = 2'd2,
        REG_LIM_H = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic                    we;
        logic [CFG_IDX_BITS-1:0] idx;
        logic [DIM_BITS-1:0]     data;
    } t_cfg_wr;

    // Frame geometry from the target calculator
    typedef struct packed {
        logic                valid;
        logic [DIM_BITS-1:0] src_w;
        logic [DIM_BITS-1:0] src_h;
        logic [DIM_BITS-1:0] tgt_w;
        logic [DIM_BITS-1:0] tgt_h;
    } t_tgt_info;

    // One kept pixel
    typedef struct packed {
        logic [PIX_BITS-1:0] pixel;
        logic [DIM_BITS-1:0] col;
        logic [DIM_BITS-1:0] row;
        logic                frame_end;
    } t_result;

    // Treat a zero size as one
    function automatic logic [DIM_BITS-1:0] at_least_one(input logic [DIM_BITS-1:0] v);
        return (v == '0) ? DIM_BITS'(1) : v;
    endfunction

endpackage

// ===== hdl/nearest_neighbor_fit_downscaler_unit.sv =====
// Channel   | Handshake        | Payload
// pixels in | push / full      | i_pixel_rgba
// results   | empty / pop      | o_out_pixel, o_out_col, o_out_row, o_frame_end
// config    | i_cfg_we         | i_cfg_idx, i_cfg_data
//
// One source pixel is taken per clock unless input stalls; a kept pixel is in
// the result queue the cycle after it is taken. The queue holds four words;
// input stalls while it is full. After reset or any configuration write the
// target size is recomputed via S_MUL, S_SEL and, if the frame exceeds the box,
// the one-bit-per-cycle divider (S_DIV) and S_FIN. A frame's first pixel waits on it.
// Reset is synchronous and active low.
// Downscaler top: target calculator, front end and result queue. Depends on nnfd_pkg.
`include "nearest_neighbor_fit_downscaler_unit_defines.svh"
module nearest_neighbor_fit_downscaler_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [nnfd_pkg::PIX_BITS-1:0]     i_pixel_rgba,
    output logic                              empty,
    input  logic                              pop,
    output logic [nnfd_pkg::PIX_BITS-1:0]     o_out_pixel,
    output logic [nnfd_pkg::DIM_BITS-1:0]     o_out_col,
    output logic [nnfd_pkg::DIM_BITS-1:0]     o_out_row,
    output logic                              o_frame_end,
    input  logic                              i_cfg_we,
    input  logic [nnfd_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [nnfd_pkg::DIM_BITS-1:0]     i_cfg_data
);
    import nnfd_pkg::*;

    t_cfg_wr   w_cfg;
    t_tgt_info w_tgt;
    logic      w_q_we, w_q_full;
    t_result   w_q_wdata, w_q_rdata;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_idx;
    assign w_cfg.data = i_cfg_data;

    nnfd_tgt u_tgt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .o_tgt   (w_tgt)
    );

    nnfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_pixel_rgba (i_pixel_rgba),
        .i_tgt        (w_tgt),
        .i_q_full     (w_q_full),
        .o_full       (full),
        .o_q_we       (w_q_we),
        .o_q_wdata    (w_q_wdata)
    );

    nnfd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_q_we),
        .i_wdata (w_q_wdata),
        .i_pop   (pop),
        .o_full  (w_q_full),
        .o_empty (empty),
        .o_rdata (w_q_rdata)
    );

    assign o_out_pixel = w_q_rdata.pixel;
    assign o_out_col   = w_q_rdata.col;
    assign o_out_row   = w_q_rdata.row;
    assign o_frame_end = w_q_rdata.frame_end;

    // A write drops the target size until it is recomputed
    `NNFD_ASSERT_NEXT(a_cfg_restart, w_cfg.we, !w_tgt.valid)
    // A finished target size stays until the next write
    `NNFD_ASSERT_NEXT(a_tgt_holds, w_tgt.valid && !w_cfg.we, w_tgt.valid)
    // Target sizes are never zero
    `NNFD_ASSERT_SAME(a_tgt_nonzero, w_tgt.valid, (w_tgt.tgt_w != '0) && (w_tgt.tgt_h != '0))
    // The queue is written only for a taken pixel
    `NNFD_ASSERT_SAME(a_we_on_accept, w_q_we, push && !full && !w_q_full)

endmodule

// ===== hdl/nnfd_tgt.sv =====
// Configuration registers and target size calculator (multiply, then, if the
// frame exceeds the box, restoring divide one quotient bit per cycle). Depends on nnfd_pkg.
module nnfd_tgt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nnfd_pkg::t_cfg_wr   i_cfg,
    output nnfd_pkg::t_tgt_info o_tgt
);
    import nnfd_pkg::*;

    typedef enum logic [2:0] {S_MUL, S_SEL, S_DIV, S_FIN, S_DONE} t_state;

    t_state                  r_state;
    logic [DIM_BITS-1:0]     r_src_w, r_src_h, r_lim_w, r_lim_h;
    logic [ACC_BITS-1:0]     r_prod_a, r_prod_b;
    logic                    r_fit_w;
    logic [ACC_BITS-1:0]     r_quo;
    logic [DIM_BITS-1:0]     r_rem;
    logic [DIM_BITS-1:0]     r_div;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [DIM_BITS-1:0]     r_tgt_w, r_tgt_h;

    logic [DIM_BITS-1:0]  w, h, lw, lh;
    logic                 need_fit;
    logic [DIM_BITS:0]    div_trial;
    logic [DIM_BITS:0]    div_diff;
    logic                 div_ge;
    logic [DIM_BITS-1:0]  quo_dim;

    // Clamp sizes and form one divide step
    always_comb begin
        w         = at_least_one(r_src_w);
        h         = at_least_one(r_src_h);
        lw        = at_least_one(r_lim_w);
        lh        = at_least_one(r_lim_h);
        need_fit  = (w > lw) || (h > lh);
        div_trial = {r_rem, r_quo[ACC_BITS-1]};
        div_ge    = div_trial >= {1'b0, r_div};
        div_diff  = div_trial - {1'b0, r_div};
        quo_dim   = at_least_one(r_quo[DIM_BITS-1:0]);
    end

    // Hold registers, restart on any write, sequence the calculation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_MUL;
            r_src_w <= DIM_RESET;
            r_src_h <= DIM_RESET;
            r_lim_w <= DIM_RESET;
            r_lim_h <= DIM_RESET;
        end else if (i_cfg.we) begin
            unique case (t_cfg_reg'(i_cfg.idx))
                REG_SRC_W: r_src_w <= i_cfg.data;
                REG_SRC_H: r_src_h <= i_cfg.data;
                REG_LIM_W: r_lim_w <= i_cfg.data;
                REG_LIM_H: r_lim_h <= i_cfg.data;
                default: ;
            endcase
            r_state <= S_MUL;
        end else begin
            unique case (r_state)
                S_MUL: begin
                    r_prod_a <= ACC_BITS'(lw) * ACC_BITS'(h);
                    r_prod_b <= ACC_BITS'(lh) * ACC_BITS'(w);
                    r_state  <= S_SEL;
                end
                S_SEL: begin
                    r_rem <= '0;
                    r_cnt <= DIV_CNT_BITS'(DIV_STEPS - 1);
                    if (!need_fit) begin
                        r_tgt_w <= w;
                        r_tgt_h <= h;
                        r_state <= S_DONE;
                    end else if (r_prod_a <= r_prod_b) begin
                        r_fit_w <= 1'b1;
                        r_quo   <= r_prod_a;
                        r_div   <= w;
                        r_state <= S_DIV;
                    end else begin
                        r_fit_w <= 1'b0;
                        r_quo   <= r_prod_b;
                        r_div   <= h;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_quo <= {r_quo[ACC_BITS-2:0], div_ge};
                    r_rem <= div_ge ? div_diff[DIM_BITS-1:0] : div_trial[DIM_BITS-1:0];
                    r_cnt <= r_cnt - DIV_CNT_BITS'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_fit_w) begin
                        r_tgt_w <= lw;
                        r_tgt_h <= quo_dim;
                    end else begin
                        r_tgt_w <= quo_dim;
                        r_tgt_h <= lh;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: ;
                default: r_state <= S_MUL;
            endcase
        end
    end

    assign o_tgt.valid = (r_state == S_DONE);
    assign o_tgt.src_w = w;
    assign o_tgt.src_h = h;
    assign o_tgt.tgt_w = r_tgt_w;
    assign o_tgt.tgt_h = r_tgt_h;

endmodule

// ===== hdl/nnfd_front.sv =====
// Front end: raster position tracking and pixel selection, one word per cycle while not full.
// Depends on nnfd_pkg; writes kept pixels into the result queue.
module nnfd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [nnfd_pkg::PIX_BITS-1:0] i_pixel_rgba,
    input  nnfd_pkg::t_tgt_info          i_tgt,
    input  logic                         i_q_full,
    output logic                         o_full,
    output logic                         o_q_we,
    output nnfd_pkg::t_result            o_q_wdata
);
    import nnfd_pkg::*;

    logic [DIM_BITS-1:0] r_src_col, r_src_row, r_next_col, r_next_row;
    logic [ACC_BITS-1:0] r_col_acc, r_row_acc, r_col_lim, r_row_lim;
    logic [DIM_BITS-1:0] r_tw, r_th;

    logic                frame_start;
    logic [DIM_BITS-1:0] eff_tw, eff_th;
    logic [ACC_BITS-1:0] col_lim, row_lim;
    logic                col_hit, row_hit, last_col, last_row, accept;

    // Classify the current source position
    always_comb begin
        frame_start = (r_src_col == '0) && (r_src_row == '0);
        eff_tw      = frame_start ? i_tgt.tgt_w : r_tw;
        eff_th      = frame_start ? i_tgt.tgt_h : r_th;
        col_lim     = (r_src_col == '0) ? ACC_BITS'(eff_tw) : r_col_lim;
        row_lim     = (r_src_row == '0) ? ACC_BITS'(eff_th) : r_row_lim;
        col_hit     = (r_next_col < eff_tw) && (r_col_acc < col_lim);
        row_hit     = (r_next_row < eff_th) && (r_row_acc < row_lim);
        last_col    = ((DIM_BITS+1)'(r_src_col) + (DIM_BITS+1)'(1)) >= (DIM_BITS+1)'(i_tgt.src_w);
        last_row    = ((DIM_BITS+1)'(r_src_row) + (DIM_BITS+1)'(1)) >= (DIM_BITS+1)'(i_tgt.src_h);
        o_full      = i_q_full || (frame_start && !i_tgt.valid);
        accept      = i_push && !o_full;
    end

    // Queue write for kept pixels
    assign o_q_we              = accept && col_hit && row_hit;
    assign o_q_wdata.pixel     = i_pixel_rgba;
    assign o_q_wdata.col       = r_next_col;
    assign o_q_wdata.row       = r_next_row;
    assign o_q_wdata.frame_end =
        (((DIM_BITS+1)'(r_next_col) + (DIM_BITS+1)'(1)) == (DIM_BITS+1)'(eff_tw)) &&
        (((DIM_BITS+1)'(r_next_row) + (DIM_BITS+1)'(1)) == (DIM_BITS+1)'(eff_th));

    // Advance position, output counters and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col  <= '0;
            r_src_row  <= '0;
            r_next_col <= '0;
            r_next_row <= '0;
            r_col_acc  <= '0;
            r_row_acc  <= '0;
            r_col_lim  <= '0;
            r_row_lim  <= '0;
            r_tw       <= '0;
            r_th       <= '0;
        end else if (accept) begin
            if (frame_start) begin
                r_tw <= i_tgt.tgt_w;
                r_th <= i_tgt.tgt_h;
            end
            if (last_col) begin
                r_src_col  <= '0;
                r_next_col <= '0;
                r_col_acc  <= '0;
                if (last_row) begin
                    r_src_row  <= '0;
                    r_next_row <= '0;
                    r_row_acc  <= '0;
                end else begin
                    r_src_row <= r_src_row + DIM_BITS'(1);
                    r_row_lim <= row_lim + ACC_BITS'(eff_th);
                    if (row_hit) begin
                        r_next_row <= r_next_row + DIM_BITS'(1);
                        r_row_acc  <= r_row_acc + ACC_BITS'(i_tgt.src_h);
                    end
                end
            end else begin
                r_src_col <= r_src_col + DIM_BITS'(1);
                r_col_lim <= col_lim + ACC_BITS'(eff_tw);
                if (col_hit) begin
                    r_next_col <= r_next_col + DIM_BITS'(1);
                    r_col_acc  <= r_col_acc + ACC_BITS'(i_tgt.src_w);
                end
            end
        end
    end

endmodule

// ===== hdl/nnfd_fifo.sv =====
// Result queue between the front end and the consumer, flop based.
// Depends on nnfd_pkg.
module nnfd_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  nnfd_pkg::t_result i_wdata,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output nnfd_pkg::t_result o_rdata
);
    import nnfd_pkg::*;

    t_result                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_cnt;
    logic                     rd;

    assign o_full  = (r_cnt == FIFO_CNT_BITS'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign rd      = i_pop && !o_empty;

    // Store words
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_we) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_BITS'(1);
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_BITS'(1);
            end
            if (i_we && !rd) begin
                r_cnt <= r_cnt + FIFO_CNT_BITS'(1);
            end else if (!i_we && rd) begin
                r_cnt <= r_cnt - FIFO_CNT_BITS'(1);
            end
        end
    end

endmodule
